### rtl/iee_pkg.sv
// Package: shared types, constants and command/status structs for the expression evaluator.
`default_nettype none
package iee_pkg;
    localparam int STACK_DEPTH = 4;
    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } mode_t;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SCAN   = 7'b0000010,
        ST_ARITH  = 7'b0000100,
        ST_DIV    = 7'b0001000,
        ST_WRBACK = 7'b0010000,
        ST_PUSH   = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic load;       // latch incoming request
        logic start_new;  // clear stacks and push number
        logic pop_op;     // pop operator, latch operands
        logic div_start;
        logic div_step;
        logic writeback;  // push arithmetic result
        logic push_item;  // push operator and number
        logic clear;      // end of expression
    } cmd_t;

    typedef struct packed {
        logic open_expr;
        logic first;
        logic last;
        logic ops_empty;
        logic reduce_ok;  // top operator ranks at or above incoming
        logic top_is_div;
        logic div_done;
    } status_t;

    function automatic logic rank_of(input logic [1:0] m);
        return m[1];
    endfunction
endpackage
`default_nettype wire

### rtl/iee_datapath.sv
// Datapath: request latch, operand and operator stacks, ALU and iterative divider.
`default_nettype none
module iee_datapath
    import iee_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        cmd,
    output status_t          sts,
    input  wire logic [35:0] in_data,
    input  wire logic        in_first,
    input  wire logic        in_last,
    output logic [31:0]      value,
    output logic             div_by_zero
);
    logic [31:0] opnd_reg [STACK_DEPTH];
    logic [1:0]  optr_reg [STACK_DEPTH];
    logic [SP_W-1:0] ocnt_reg, pcnt_reg;
    logic err_reg, first_reg, last_reg;
    logic [1:0] mode_reg;
    logic [31:0] num_reg;
    logic [31:0] lhs_reg, rhs_reg, res_reg;
    logic [1:0] op_reg;
    logic [31:0] rem_reg, quo_reg, dvs_reg;
    logic [5:0] dcnt_reg;
    logic neg_reg;

    logic [31:0] top_a;
    logic [31:0] ua, ub, arith;
    logic [32:0] trial;
    logic [SP_W-1:0] ocm1, ocm2, pcm1;

    assign ocm1 = ocnt_reg - SP_W'(1);
    assign ocm2 = ocnt_reg - SP_W'(2);
    assign pcm1 = pcnt_reg - SP_W'(1);
    assign top_a = opnd_reg[ocm1[IDX_W-1:0]];
    assign ua = lhs_reg[31] ? 32'd0 - lhs_reg : lhs_reg;
    assign ub = rhs_reg[31] ? 32'd0 - rhs_reg : rhs_reg;
    assign trial = {rem_reg, quo_reg[31]} - {1'b0, dvs_reg};

    always_comb
    begin
        case (op_reg)
            MODE_ADD: arith = lhs_reg + rhs_reg;
            MODE_SUB: arith = lhs_reg - rhs_reg;
            MODE_MUL: arith = 32'(lhs_reg * rhs_reg);
            default:  arith = 32'd0;
        endcase
    end

    assign sts.open_expr = ocnt_reg != '0;
    assign sts.first = first_reg;
    assign sts.last = last_reg;
    assign sts.ops_empty = pcnt_reg == '0;
    assign sts.reduce_ok = pcnt_reg != '0 &&
        rank_of(mode_reg) <= rank_of(optr_reg[pcm1[IDX_W-1:0]]);
    assign sts.top_is_div = op_reg == MODE_DIV;
    assign sts.div_done = dcnt_reg == 6'd0;

    assign value = err_reg ? 32'd0 : (ocnt_reg != '0 ? top_a : 32'd0);
    assign div_by_zero = err_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= in_data[1:0];
            num_reg <= in_data[33:2];
        end
        if (cmd.start_new)
            opnd_reg[0] <= num_reg;
        if (cmd.pop_op)
        begin
            op_reg <= optr_reg[pcm1[IDX_W-1:0]];
            rhs_reg <= top_a;
            lhs_reg <= opnd_reg[ocm2[IDX_W-1:0]];
        end
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= ua;
            dvs_reg <= ub;
            neg_reg <= lhs_reg[31] ^ rhs_reg[31];
        end
        if (cmd.div_step)
        begin
            if (!trial[32])
            begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[30:0], quo_reg[31]};
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
        if (cmd.writeback)
            opnd_reg[ocm2[IDX_W-1:0]] <= res_reg;
        if (cmd.push_item)
        begin
            opnd_reg[ocnt_reg[IDX_W-1:0]] <= num_reg;
            optr_reg[pcnt_reg[IDX_W-1:0]] <= mode_reg;
        end
    end

    always_comb
    begin
        res_reg = op_reg == MODE_DIV ?
            (dvs_reg == 32'd0 ? 32'd0 : (neg_reg ? 32'd0 - quo_reg : quo_reg)) : arith;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ocnt_reg <= '0;
            pcnt_reg <= '0;
            err_reg <= 1'b0;
            first_reg <= 1'b0;
            last_reg <= 1'b0;
            dcnt_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                first_reg <= in_first;
                last_reg <= in_last;
            end
            if (cmd.div_start)
                dcnt_reg <= 6'd32;
            else if (cmd.div_step && dcnt_reg != 6'd0)
                dcnt_reg <= dcnt_reg - 6'd1;
            if (cmd.div_start && ub == 32'd0)
                err_reg <= 1'b1;
            if (cmd.start_new)
            begin
                ocnt_reg <= SP_W'(1);
                pcnt_reg <= '0;
                err_reg <= 1'b0;
            end
            else if (cmd.clear)
            begin
                ocnt_reg <= '0;
                pcnt_reg <= '0;
                err_reg <= 1'b0;
            end
            else if (cmd.pop_op)
                pcnt_reg <= pcm1;
            else if (cmd.writeback)
                ocnt_reg <= ocm1;
            else if (cmd.push_item)
            begin
                ocnt_reg <= ocnt_reg + SP_W'(1);
                pcnt_reg <= pcnt_reg + SP_W'(1);
            end
        end
    end
endmodule
`default_nettype wire

### rtl/iee_ctrl.sv
// Controller: sequences load, reduction, division, push and emit.
`default_nettype none
module iee_ctrl
    import iee_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire status_t sts,
    output cmd_t         cmd,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  wire logic    m_tready
);
    state_t state_reg, state_next;
    logic drain_reg, drain_next;

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = state_reg == ST_EMIT;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        drain_next = drain_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    drain_next = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.first || !sts.open_expr)
                begin
                    cmd.start_new = 1'b1;
                    drain_next = sts.last;
                    state_next = sts.last ? ST_PUSH : ST_IDLE;
                end
                else
                    state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                // reduce by rank, push the item, then on last drain the stack
                if (drain_reg && !sts.ops_empty)
                begin
                    cmd.pop_op = 1'b1;
                    state_next = ST_ARITH;
                end
                else if (drain_reg)
                    state_next = ST_EMIT;
                else if (sts.reduce_ok)
                begin
                    cmd.pop_op = 1'b1;
                    state_next = ST_ARITH;
                end
                else
                begin
                    cmd.push_item = 1'b1;
                    drain_next = sts.last;
                    state_next = sts.last ? ST_PUSH : ST_IDLE;
                end
            end
            ST_ARITH:
            begin
                if (sts.top_is_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DIV;
                end
                else
                    state_next = ST_WRBACK;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    cmd.div_step = 1'b0;
                    state_next = ST_WRBACK;
                end
            end
            ST_WRBACK:
            begin
                cmd.writeback = 1'b1;
                state_next = ST_PUSH;
            end
            ST_EMIT:
            begin
                if (m_tready)
                begin
                    cmd.clear = 1'b1;
                    drain_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            drain_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            drain_reg <= drain_next;
        end
    end
endmodule
`default_nettype wire

### rtl/infix_expression_evaluator.sv
// Top level: infix integer expression evaluator with operand and operator stacks.
// Input stream s_*: one request per item, a leading number or an (operator, number) pair.
// s_tuser bit 0 is first; s_tlast ends the expression. Output stream m_*: one request
// per expression carrying value and div_by_zero.
// One request is taken at a time; s_tready is high only while idle.
// A leading number is loaded and then starts a new expression; a continuation item is
// loaded, scanned, then pushed after any reductions (pop, arith, writeback); a divide
// reduction adds the bit-serial restoring divider, one quotient bit a cycle.
// A final item is pushed, then the operator stack is drained with the same reductions;
// the result is then held on m_* until m_tready; while the receiver stalls, no new
// request is taken.
// Division by zero yields 0 for that step; the expression then reports value 0
// with div_by_zero set. Stack depth is STACK_DEPTH from the package.
// Reset clears both stack counts, the error flag and the controller; stack
// contents are not cleared and are never read before being written.
`default_nettype none
module infix_expression_evaluator
    import iee_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // [1:0] mode, [33:2] number, zero fill
    input  wire logic        s_tuser,   // [0] first
    input  wire logic        s_tlast,   // last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] value
    output logic             m_tuser    // [0] div_by_zero
);
    cmd_t cmd;
    status_t sts;

    iee_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .sts(sts), .cmd(cmd),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready)
    );

    iee_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .in_data(s_tdata[35:0]), .in_first(s_tuser), .in_last(s_tlast),
        .value(m_tdata), .div_by_zero(m_tuser)
    );

    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready) else $error("input taken during emit");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready) else $error("second request too soon");
endmodule
`default_nettype wire
